[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the RTL of the DMC regulator step.
// Checks are compiled in unless SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every rising edge of clk_i while rst_ni is high.
`define DMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dmc assertion failed");
// Checked on every rising edge of clk_i, reset included.
`define DMC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("dmc assertion failed");
`else
`define DMC_ASSERT(lbl, prop)
`define DMC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/core/dmc_pkg.sv]
// ----------------------------------------------------------------------------
// dmc_pkg
// Constants, types and the coefficient table of the DMC regulator step.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

  // Prediction horizon; the history holds HORIZON-1 past increments.
  localparam int unsigned HORIZON    = 100;
  localparam int unsigned HIST_DEPTH = HORIZON - 1;
  localparam int unsigned HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int unsigned FILL_W     = $clog2(HIST_DEPTH + 1);

  // Field widths.
  localparam int unsigned DATA_W = 24;  // Q15.8 drive and increment
  localparam int unsigned MEAS_W = 16;  // setpoint and measurement
  localparam int unsigned GAIN_W = 16;  // Q1.14 error gain
  localparam int unsigned COEF_W = 16;  // Q1.15 coefficients
  localparam int unsigned ERR_W  = MEAS_W + 1;

  // Shared multiplier and accumulator.
  localparam int unsigned MUL_A_W   = DATA_W;
  localparam int unsigned MUL_B_W   = ERR_W;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned ERR_SHIFT = 9;   // Q1.14 * integer -> Q.23
  localparam int unsigned RND_SHIFT = 15;  // Q.23 -> Q15.8
  localparam int unsigned RND_W     = ACC_W - RND_SHIFT;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W    = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_GAIN = 8'd1;

  localparam logic [MEAS_W-1:0] SETPOINT_RST = 16'd1500;
  localparam logic [GAIN_W-1:0] GAIN_RST     = 16'd13093;

  typedef struct packed {
    logic push;   // store last increment as newest history entry
    logic rd_en;  // issue one history read and advance to the next older entry
  } hist_ctrl_t;

  typedef struct packed {
    logic                valid;  // read data below belongs to an issued read
    logic                live;   // entry was written since reset
    logic [DATA_W-1:0]   data;
    logic [COEF_W-1:0]   coef;
  } hist_rd_t;

  typedef struct packed {
    logic clear;   // zero the accumulator
    logic err_en;  // multiply gain by control error this cycle
  } mac_ctrl_t;

  // Tuned coefficients, Q1.15, by history age. Entries past the tuned set are zero.
  function automatic logic signed [COEF_W-1:0] coef_rom(input logic [HIST_AW-1:0] idx);
    int unsigned i;
    logic signed [COEF_W-1:0] c;
    i = 32'(idx);
    unique case (i)
      0:  c = 16'sd15607;
      1:  c = 16'sd15593;
      2:  c = 16'sd14494;
      3:  c = 16'sd12887;
      4:  c = 16'sd11264;
      5:  c = 16'sd9560;
      6:  c = 16'sd8178;
      7:  c = 16'sd6718;
      8:  c = 16'sd5601;
      9:  c = 16'sd4540;
      10: c = 16'sd3693;
      11: c = 16'sd3093;
      12: c = 16'sd2634;
      13: c = 16'sd2171;
      14: c = 16'sd1748;
      15: c = 16'sd1399;
      16: c = 16'sd1158;
      17: c = 16'sd924;
      18: c = 16'sd848;
      19: c = 16'sd699;
      20: c = 16'sd404;
      21: c = 16'sd487;
      22: c = 16'sd385;
      23: c = 16'sd358;
      24: c = 16'sd297;
      25: c = 16'sd417;
      26: c = 16'sd218;
      27: c = 16'sd98;
      28: c = 16'sd219;
      29: c = -16'sd125;
      30: c = 16'sd48;
      31: c = 16'sd105;
      32: c = 16'sd146;
      33: c = 16'sd6;
      34: c = -16'sd50;
      35: c = -16'sd74;
      36: c = 16'sd3;
      37: c = 16'sd24;
      38: c = -16'sd52;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/dmc_hist_buf.sv]
// ----------------------------------------------------------------------------
// dmc_hist_buf
// Circular history of past increments with a registered read port that walks
// from the newest entry to the oldest, paired with the matching coefficient.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_hist_buf (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire dmc_pkg::hist_ctrl_t          ctrl_i,
  input  wire logic [dmc_pkg::DATA_W-1:0]   push_data_i,
  output dmc_pkg::hist_rd_t                 rd_o,
  output logic                              rd_last_o
);

  localparam logic [dmc_pkg::HIST_AW-1:0] LAST_ADDR = dmc_pkg::HIST_AW'(dmc_pkg::HIST_DEPTH - 1);
  localparam logic [dmc_pkg::FILL_W-1:0]  FULL      = dmc_pkg::FILL_W'(dmc_pkg::HIST_DEPTH);

  logic [dmc_pkg::DATA_W-1:0]  mem [dmc_pkg::HIST_DEPTH];

  logic [dmc_pkg::HIST_AW-1:0] head_q, head_d, head_inc;
  logic [dmc_pkg::HIST_AW-1:0] addr_q, addr_d;
  logic [dmc_pkg::HIST_AW-1:0] age_q, age_d;
  logic [dmc_pkg::FILL_W-1:0]  fill_q, fill_d;
  logic                        rd_valid_q, rd_live_q;
  logic [dmc_pkg::DATA_W-1:0]  rd_data_q;
  logic [dmc_pkg::COEF_W-1:0]  rd_coef_q;

  assign head_inc = (head_q == LAST_ADDR) ? '0 : head_q + 1'b1;

  always_comb begin
    head_d = head_q;
    addr_d = addr_q;
    age_d  = age_q;
    fill_d = fill_q;
    if (ctrl_i.push) begin
      head_d = head_inc;
      addr_d = head_inc;
      age_d  = '0;
      if (fill_q != FULL) begin
        fill_d = fill_q + 1'b1;
      end
    end else if (ctrl_i.rd_en) begin
      addr_d = (addr_q == '0) ? LAST_ADDR : addr_q - 1'b1;
      age_d  = age_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      addr_q     <= '0;
      age_q      <= '0;
      fill_q     <= '0;
      rd_valid_q <= 1'b0;
      rd_live_q  <= 1'b0;
    end else begin
      head_q     <= head_d;
      addr_q     <= addr_d;
      age_q      <= age_d;
      fill_q     <= fill_d;
      rd_valid_q <= ctrl_i.rd_en;
      // Entries never written since reset are marked not live; the multiplier treats them as zero.
      rd_live_q  <= dmc_pkg::FILL_W'(age_q) < fill_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[head_inc] <= push_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[addr_q];
      rd_coef_q <= dmc_pkg::coef_rom(age_q);
    end
  end

  assign rd_last_o  = (age_q == LAST_ADDR);
  assign rd_o.valid = rd_valid_q;
  assign rd_o.live  = rd_live_q;
  assign rd_o.data  = rd_data_q;
  assign rd_o.coef  = rd_coef_q;

endmodule

`default_nettype wire

[rtl/core/dmc_mac.sv]
// ----------------------------------------------------------------------------
// dmc_mac
// Shared signed multiplier with a registered product, followed by the
// accumulator. Adds the gain term, subtracts every coefficient product.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_mac (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire dmc_pkg::mac_ctrl_t                  ctrl_i,
  input  wire logic signed [dmc_pkg::GAIN_W-1:0]   gain_i,
  input  wire logic signed [dmc_pkg::ERR_W-1:0]    err_i,
  input  wire dmc_pkg::hist_rd_t                   rd_i,
  output logic signed [dmc_pkg::ACC_W-1:0]         acc_o,
  output logic                                     busy_o
);

  logic signed [dmc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [dmc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [dmc_pkg::PROD_W-1:0]  prod_d, prod_q;
  logic signed [dmc_pkg::ACC_W-1:0]   prod_ext;
  logic signed [dmc_pkg::ACC_W-1:0]   acc_q;
  logic                               pvld_q, perr_q;

  always_comb begin
    if (ctrl_i.err_en) begin
      mul_a = dmc_pkg::MUL_A_W'(gain_i);
      mul_b = err_i;
    end else begin
      mul_a = rd_i.live ? $signed(rd_i.data) : '0;
      mul_b = dmc_pkg::MUL_B_W'($signed(rd_i.coef));
    end
  end

  assign prod_d   = dmc_pkg::PROD_W'(mul_a) * dmc_pkg::PROD_W'(mul_b);
  assign prod_ext = dmc_pkg::ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
      perr_q <= 1'b0;
    end else begin
      pvld_q <= ctrl_i.err_en | rd_i.valid;
      perr_q <= ctrl_i.err_en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (pvld_q) begin
      if (perr_q) begin
        acc_q <= acc_q + (prod_ext <<< dmc_pkg::ERR_SHIFT);
      end else begin
        acc_q <= acc_q - prod_ext;
      end
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = rd_i.valid | pvld_q;

endmodule

`default_nettype wire

[rtl/core/dmc_controller_step.sv]
// ----------------------------------------------------------------------------
// dmc_controller_step
// Analytic DMC regulator step in fixed point.
//
// Input channel (in_valid_i / in_ready_o) carries the previous drive value
// (Q15.8) and the measured process output. Each transfer produces exactly
// one result on the output channel (out_valid_o / out_ready_i): the new drive,
// the control increment (both Q15.8, saturated) and a saturation flag.
// The configuration channel writes the setpoint (index 0) and the error gain
// (index 1, Q1.14); other indexes are ignored. It is always ready.
// Each item passes through one gain multiply plus one multiply-accumulate per
// history entry (99) on the single shared multiplier, fed by the one read port
// of the history memory, then pipeline drain, rounding and the drive add. The
// block takes no new item while one is being computed. A finished result waits
// in the output register; the next item may be accepted meanwhile, and its own
// result waits in the sequencer until the output register is free. Reset clears
// the history (by a fill count, no clearing pass), the last increment and the
// output valid, and loads the setpoint 1500 and the gain 13093.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dmc_controller_step (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Configuration writes.
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [dmc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [dmc_pkg::MEAS_W-1:0]           cfg_data_i,
  // Sample input.
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [dmc_pkg::DATA_W-1:0]    prev_drive_i,
  input  wire logic [dmc_pkg::MEAS_W-1:0]           measured_i,
  // Result output.
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [dmc_pkg::DATA_W-1:0]         drive_o,
  output logic signed [dmc_pkg::DATA_W-1:0]         increment_o,
  output logic                                      saturated_o
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ERR   = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam int unsigned DW = dmc_pkg::DATA_W;
  localparam logic signed [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [dmc_pkg::ACC_W-1:0] RND_BIAS =
    dmc_pkg::ACC_W'(1) <<< (dmc_pkg::RND_SHIFT - 1);

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [dmc_pkg::MEAS_W-1:0]         setpoint_q;
  logic signed [dmc_pkg::GAIN_W-1:0]  gain_q;

  // Per-item working registers.
  logic signed [DW-1:0]               prev_q;
  logic signed [dmc_pkg::ERR_W-1:0]   err_q;
  logic signed [DW-1:0]               last_inc_q;
  logic signed [DW-1:0]               inc_q;
  logic                               sat_q;

  // Output register.
  logic                               out_vld_q;
  logic signed [DW-1:0]               drive_out_q, inc_out_q;
  logic                               sat_out_q;

  logic                               in_fire, out_load;
  dmc_pkg::hist_ctrl_t                hist_ctrl;
  dmc_pkg::hist_rd_t                  hist_rd;
  dmc_pkg::mac_ctrl_t                 mac_ctrl;
  logic                               rd_last, mac_busy;
  logic signed [dmc_pkg::ACC_W-1:0]   acc;
  logic signed [dmc_pkg::ACC_W-1:0]   acc_rnd;
  logic signed [dmc_pkg::RND_W-1:0]   inc_wide;
  logic                               inc_ovf;
  logic signed [DW-1:0]               inc_clip;
  logic signed [DW:0]                 drive_sum;
  logic                               drive_ovf;
  logic signed [DW-1:0]               drive_clip;

  // --------------------------------------------------------------------------
  // Configuration writes must only arrive while the block is idle; the block does not enforce this.
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= dmc_pkg::SETPOINT_RST;
      gain_q     <= dmc_pkg::GAIN_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == dmc_pkg::REG_SETPOINT) begin
        setpoint_q <= cfg_data_i;
      end
      if (cfg_index_i == dmc_pkg::REG_ERROR_GAIN) begin
        gain_q <= $signed(cfg_data_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer. The history push happens in the transfer cycle, the gain term
  // goes through the multiplier next, then one history read per cycle.
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_load   = (state_q == S_DONE) & (!out_vld_q | out_ready_i);

  assign hist_ctrl.push  = in_fire;
  assign hist_ctrl.rd_en = (state_q == S_MAC);
  assign mac_ctrl.clear  = in_fire;
  assign mac_ctrl.err_en = (state_q == S_ERR);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_ERR;
      S_ERR:   state_d = S_MAC;
      S_MAC:   if (rd_last) state_d = S_DRAIN;
      S_DRAIN: if (!mac_busy) state_d = S_ROUND;
      S_ROUND: state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      last_inc_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_ROUND) begin
        last_inc_q <= inc_clip;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath around the shared unit.
  // --------------------------------------------------------------------------
  dmc_hist_buf u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (hist_ctrl),
    .push_data_i (last_inc_q),
    .rd_o        (hist_rd),
    .rd_last_o   (rd_last)
  );

  dmc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .gain_i (gain_q),
    .err_i  (err_q),
    .rd_i   (hist_rd),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  // Round half up from Q.23 to Q15.8, then clip to the 24-bit field.
  assign acc_rnd  = acc + RND_BIAS;
  assign inc_wide = acc_rnd[dmc_pkg::ACC_W-1:dmc_pkg::RND_SHIFT];
  assign inc_ovf  = !((inc_wide[dmc_pkg::RND_W-1:DW-1] == '0) ||
                      (inc_wide[dmc_pkg::RND_W-1:DW-1] == '1));
  assign inc_clip = inc_ovf ? (inc_wide[dmc_pkg::RND_W-1] ? Q_MIN : Q_MAX)
                            : inc_wide[DW-1:0];

  // Previous drive plus the clipped increment, clipped again.
  assign drive_sum  = (DW+1)'(prev_q) + (DW+1)'(inc_q);
  assign drive_ovf  = drive_sum[DW] != drive_sum[DW-1];
  assign drive_clip = drive_ovf ? (drive_sum[DW] ? Q_MIN : Q_MAX) : drive_sum[DW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prev_q <= prev_drive_i;
      err_q  <= $signed({1'b0, setpoint_q}) - $signed({1'b0, measured_i});
    end
    if (state_q == S_ROUND) begin
      inc_q <= inc_clip;
      sat_q <= inc_ovf;
    end
    if (out_load) begin
      drive_out_q <= drive_clip;
      inc_out_q   <= inc_q;
      sat_out_q   <= sat_q | drive_ovf;
    end
  end

  assign out_valid_o = out_vld_q;
  assign drive_o     = drive_out_q;
  assign increment_o = inc_out_q;
  assign saturated_o = sat_out_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // The shared unit holds no work from an earlier item when a new one can enter.
  `DMC_ASSERT(a_idle_unit_empty, in_ready_o |-> !mac_busy)
  // A result enters the output register only from the final sequencer step.
  `DMC_ASSERT(a_out_from_done, $rose(out_valid_o) |-> $past(state_q == S_DONE))
  // The block stops taking items only because one was just transferred.
  `DMC_ASSERT(a_ready_falls_on_transfer, $fell(in_ready_o) |-> $past(in_valid_i))

endmodule

`default_nettype wire

[tb/dmc_controller_step_test.sv]
// ----------------------------------------------------------------------------
// dmc_controller_step_test
// Self-checking testbench for the fixed-point DMC regulator step. Samples go
// in over the valid/ready input channel, and a scoreboard with its own copy
// of the increment history, coefficient table and registers predicts every
// result. A short directed part covers field extremes and both saturation
// cases. It is followed by random phases: mostly closed-loop samples around
// the setpoint, plus noise, at several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [dmc_pkg::DATA_W-1:0] drive;
  logic signed [dmc_pkg::DATA_W-1:0] increment;
  logic                              saturated;
} drive_result_t;

class drive_scoreboard;
  logic [dmc_pkg::MEAS_W-1:0]        setpoint;
  logic signed [dmc_pkg::GAIN_W-1:0] error_gain;
  logic signed [dmc_pkg::DATA_W-1:0] last_increment;
  logic signed [dmc_pkg::DATA_W-1:0] increment_history [dmc_pkg::HIST_DEPTH];
  logic signed [dmc_pkg::COEF_W-1:0] tap_weights [dmc_pkg::HIST_DEPTH];
  drive_result_t                     expected_drives [$];
  int                                mismatches;

  function new();
    int tuned [39];
    tuned = '{15607, 15593, 14494, 12887, 11264, 9560, 8178, 6718, 5601, 4540,
              3693, 3093, 2634, 2171, 1748, 1399, 1158, 924, 848, 699,
              404, 487, 385, 358, 297, 417, 218, 98, 219, -125,
              48, 105, 146, 6, -50, -74, 3, 24, -52};
    setpoint       = dmc_pkg::SETPOINT_RST;
    error_gain     = dmc_pkg::GAIN_RST;
    last_increment = '0;
    mismatches     = 0;
    for (int i = 0; i < dmc_pkg::HIST_DEPTH; i++) begin
      increment_history[i] = '0;
      tap_weights[i]       = (i < 39) ? dmc_pkg::COEF_W'(tuned[i]) : '0;
    end
  endfunction

  function void write_reg(logic [dmc_pkg::CFG_IDX_W-1:0] idx, logic [dmc_pkg::MEAS_W-1:0] data);
    case (idx)
      dmc_pkg::REG_SETPOINT:   setpoint = data;
      dmc_pkg::REG_ERROR_GAIN: error_gain = data;
      default: ;
    endcase
  endfunction

  function longint clamp_q24(longint x, inout bit clipped);
    if (x > 64'sd8388607) begin
      clipped = 1'b1;
      return 64'sd8388607;
    end
    if (x < -64'sd8388608) begin
      clipped = 1'b1;
      return -64'sd8388608;
    end
    return x;
  endfunction

  // Predicts the result of one accepted sample and returns the new drive.
  function logic signed [dmc_pkg::DATA_W-1:0] note_sample(
      logic signed [dmc_pkg::DATA_W-1:0] prev_drive, logic [dmc_pkg::MEAS_W-1:0] measured);
    longint        acc;
    longint        inc;
    longint        drv;
    bit            clipped;
    drive_result_t want;
    clipped = 1'b0;
    for (int i = dmc_pkg::HIST_DEPTH - 1; i > 0; i--)
      increment_history[i] = increment_history[i-1];
    increment_history[0] = last_increment;
    acc = longint'(error_gain) * (longint'({1'b0, setpoint}) - longint'({1'b0, measured})) * 512;
    for (int i = 0; i < dmc_pkg::HIST_DEPTH; i++)
      acc -= longint'(tap_weights[i]) * longint'(increment_history[i]);
    // Round half up: add one half, then arithmetic shift floors.
    inc = clamp_q24((acc + 64'sd16384) >>> 15, clipped);
    last_increment = inc[dmc_pkg::DATA_W-1:0];
    drv = clamp_q24(longint'(prev_drive) + inc, clipped);
    want.drive     = drv[dmc_pkg::DATA_W-1:0];
    want.increment = inc[dmc_pkg::DATA_W-1:0];
    want.saturated = clipped;
    expected_drives.push_back(want);
    return want.drive;
  endfunction

  function void check_result(logic signed [dmc_pkg::DATA_W-1:0] drive,
                             logic signed [dmc_pkg::DATA_W-1:0] increment, logic saturated);
    drive_result_t want;
    if (expected_drives.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result with nothing pending: drive=%0d increment=%0d saturated=%0b",
                 drive, increment, saturated);
      return;
    end
    want = expected_drives.pop_front();
    if (drive !== want.drive || increment !== want.increment || saturated !== want.saturated) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: mismatch: expected drive=%0d increment=%0d saturated=%0b",
                 want.drive, want.increment, want.saturated);
        $display("       got drive=%0d increment=%0d saturated=%0b",
                 drive, increment, saturated);
      end
    end
  endfunction

  function int pending();
    return expected_drives.size();
  endfunction
endclass

module dmc_controller_step_test;

  // Register indexes that the block does not decode; writes to them must be dropped.
  localparam logic [dmc_pkg::CFG_IDX_W-1:0] UNMAPPED_REG_LO = 8'd2;
  localparam logic [dmc_pkg::CFG_IDX_W-1:0] UNMAPPED_REG_HI = 8'hFF;

  // The final drain waits longer than the time from an input transfer to its result.
  // The watchdog allows many times the longest legal stretch without any transfer
  // (compute time plus both random waits).
  localparam int DRAIN_CYCLES   = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 250;

  logic                                 clk_i        = 1'b0;
  logic                                 rst_ni       = 1'b0;
  logic                                 cfg_valid_i  = 1'b0;
  logic                                 cfg_ready_o;
  logic [dmc_pkg::CFG_IDX_W-1:0]        cfg_index_i  = '0;
  logic [dmc_pkg::MEAS_W-1:0]           cfg_data_i   = '0;
  logic                                 in_valid_i   = 1'b0;
  logic                                 in_ready_o;
  logic signed [dmc_pkg::DATA_W-1:0]    prev_drive_i = '0;
  logic [dmc_pkg::MEAS_W-1:0]           measured_i   = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i  = 1'b0;
  logic signed [dmc_pkg::DATA_W-1:0]    drive_o;
  logic signed [dmc_pkg::DATA_W-1:0]    increment_o;
  logic                                 saturated_o;

  drive_scoreboard                   sb = new();
  // When set, both sides run back to back, without waiting between transfers.
  bit                                no_idle = 1'b0;
  // Drive predicted for the latest sample; it feeds the closed-loop stimulus.
  logic signed [dmc_pkg::DATA_W-1:0] loop_drive = '0;
  int                                idle_cycles = 0;

  dmc_controller_step u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .prev_drive_i (prev_drive_i),
    .measured_i   (measured_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .drive_o      (drive_o),
    .increment_o  (increment_o),
    .saturated_o  (saturated_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // Offers one sample after a random wait and returns at the edge of its transfer.
  // Valid stays high after the transfer. The next call lowers it, or keeps it
  // high, with a single assignment in that same time step.
  task automatic push_sample(logic signed [dmc_pkg::DATA_W-1:0] prev,
                             logic [dmc_pkg::MEAS_W-1:0] meas);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    prev_drive_i <= prev;
    measured_i   <= meas;
    do @(posedge clk_i); while (!in_ready_o);
    loop_drive = sb.note_sample(prev, meas);
  endtask

  // Same idea on the configuration channel, without the random wait; the caller lowers valid after the last write.
  task automatic write_reg(logic [dmc_pkg::CFG_IDX_W-1:0] idx, logic [dmc_pkg::MEAS_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  // Stops offering samples and waits until every predicted result has come back,
  // so that the block is idle before its registers change.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Writes both registers plus one undecoded index, which must leave both untouched.
  task automatic apply_config(logic [dmc_pkg::MEAS_W-1:0] sp, logic [dmc_pkg::GAIN_W-1:0] gain);
    write_reg(($urandom_range(0, 1) == 0) ? UNMAPPED_REG_LO : UNMAPPED_REG_HI,
              dmc_pkg::MEAS_W'($urandom()));
    write_reg(dmc_pkg::REG_SETPOINT, sp);
    write_reg(dmc_pkg::REG_ERROR_GAIN, gain);
    cfg_valid_i <= 1'b0;
  endtask

  // The receiver waits a random number of cycles per result, then holds ready
  // high until the transfer.
  initial begin
    int gap;
    forever begin
      gap = draw_wait();
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Results are sampled at the edge, where both handshake signals still hold
  // their values from before it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(drive_o, increment_o, saturated_o);
  end

  // Watchdog: a long stretch with no transfer on any channel means the block hung.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [dmc_pkg::MEAS_W-1:0]        sp;
    logic [dmc_pkg::GAIN_W-1:0]        gain;
    logic signed [dmc_pkg::DATA_W-1:0] prev;
    logic [dmc_pkg::MEAS_W-1:0]        meas;
    int                                m;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the reset settings first. Zero error with an empty
    // history gives a zero increment. A full-scale positive drive plus a positive
    // increment clips the drive, and a measurement far above the setpoint
    // clips the increment negative.
    push_sample(24'sd0, 16'd1500);
    push_sample(24'sd0, 16'd0);
    push_sample(24'sh7FFFFF, 16'd0);
    push_sample(-24'sh800000, 16'hFFFF);
    push_sample(-24'sd1, 16'd1500);
    push_sample(24'sd1, 16'd1499);
    settle();

    // Largest positive gain and error: the increment clips positive, and so
    // does the drive from full scale.
    apply_config(16'hFFFF, 16'h7FFF);
    push_sample(24'sh7FFFFF, 16'd0);
    push_sample(-24'sh800000, 16'd0);
    push_sample(24'sd0, 16'hFFFF);
    settle();

    // Most negative gain with the setpoint at zero.
    apply_config(16'd0, 16'h8000);
    push_sample(24'sd0, 16'hFFFF);
    push_sample(24'sd0, 16'd0);
    push_sample(-24'sh800000, 16'hFFFF);
    settle();

    // Zero gain: only the history term acts.
    apply_config(16'd1500, 16'd0);
    push_sample(24'sd0, 16'd1500);
    push_sample(24'sd0, 16'd1500);
    push_sample(24'sh123456, 16'h5A5A);
    push_sample(-24'sh6DCBA9, 16'hA5A5);
    settle();

    // Back to the reset values before the random part.
    apply_config(dmc_pkg::SETPOINT_RST, dmc_pkg::GAIN_RST);
    push_sample(24'sd0, 16'd1500);
    push_sample(24'sd0, 16'd1400);
    settle();

    // Random phases. Each phase picks new register values, extremes included.
    // Most samples close the loop: the previous predicted drive comes back as
    // prev_drive, with a measurement near the setpoint. The rest are full-range
    // noise and extreme corners.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0:       sp = 16'd0;
        1:       sp = 16'hFFFF;
        2:       sp = dmc_pkg::SETPOINT_RST;
        default: sp = dmc_pkg::MEAS_W'($urandom());
      endcase
      case ($urandom_range(0, 5))
        0:       gain = 16'h8000;
        1:       gain = 16'h7FFF;
        2:       gain = 16'd0;
        3:       gain = dmc_pkg::GAIN_RST;
        4:       gain = dmc_pkg::GAIN_W'($urandom());
        default: gain = 16'($urandom_range(0, 16383));
      endcase
      apply_config(sp, gain);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0)
          no_idle = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
          0, 1: begin
            prev = dmc_pkg::DATA_W'($urandom());
            meas = dmc_pkg::MEAS_W'($urandom());
          end
          2: begin
            case ($urandom_range(0, 3))
              0:       prev = 24'sh7FFFFF;
              1:       prev = -24'sh800000;
              2:       prev = -24'sd1;
              default: prev = 24'sd0;
            endcase
            meas = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
          end
          default: begin
            prev = loop_drive;
            m = int'(sb.setpoint) + int'($urandom_range(0, 400)) - 200;
            if (m < 0)
              m = 0;
            if (m > 65535)
              m = 65535;
            meas = dmc_pkg::MEAS_W'(m);
          end
        endcase
        push_sample(prev, meas);
      end
      settle();
    end

    // All samples are done; give a stray result time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[dmc_controller_step.f]
+incdir+rtl/core
rtl/core/dmc_pkg.sv
rtl/core/dmc_hist_buf.sv
rtl/core/dmc_mac.sv
rtl/core/dmc_controller_step.sv
tb/dmc_controller_step_test.sv
